// File: design/rotation_angle_sequence_analyzer_top_macros.svh
// Assertion macros used by the top-level file to check this block.
`ifndef ROTATION_ANGLE_SEQUENCE_ANALYZER_TOP_MACROS_SVH
`define ROTATION_ANGLE_SEQUENCE_ANALYZER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RASA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rasa check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define RASA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rasa check failed in the following cycle");

`endif

// File: design/rasa_pkg.sv
package rasa_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int MAX_ITEMS  = 4096;
	localparam int COUNT_W    = 13;
	localparam int SUM_W      = 28;
	localparam int RANGE_W    = ANGLE_BITS + 1;
	localparam int DIV_STEPS  = SUM_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// Top two phase bits of the first and the fourth quadrant.
	localparam logic [1:0] QUAD_1 = 2'b00;
	localparam logic [1:0] QUAD_4 = 2'b11;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle_phase;
		logic                  final_item;
	} angle_word_t;

	typedef struct packed {
		logic [ANGLE_BITS-1:0] relative_angle;
		logic                  relative_valid;
		logic                  direction_ccw;
		logic                  summary_valid;
		logic [ANGLE_BITS-1:0] mean_increment;
		logic [RANGE_W-1:0]    angle_range;
		logic [COUNT_W-1:0]    projections_per_rotation;
		logic                  result_last;
	} result_word_t;

	typedef struct packed {
		logic accept;
		logic load_item;
		logic div_step;
		logic load_summary;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} status_t;

endpackage

// File: design/rasa_ctrl.sv
module rasa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              angle_valid,
	output logic              angle_stall,
	output logic              result_valid,
	input  logic              result_stall,
	input  rasa_pkg::status_t status,
	output rasa_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV    = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;

	// The output register can take a word when empty or emptied this cycle.
	assign out_free    = !out_valid_q || !result_stall;
	assign angle_stall = !((state_q == ST_IDLE) && out_free);
	assign accept      = angle_valid && !angle_stall;
	assign result_valid = out_valid_q;

	always_comb begin
		state_n          = state_q;
		cmd.accept       = accept;
		cmd.load_item    = accept && !status.need_div;
		cmd.div_step     = 1'b0;
		cmd.load_summary = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && status.need_div) begin
					state_n = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_n = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_summary = 1'b1;
					state_n          = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_item || cmd.load_summary) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/rasa_datapath.sv
module rasa_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rasa_pkg::angle_word_t  angle_word,
	input  rasa_pkg::cmd_t         cmd,
	output rasa_pkg::status_t      status,
	output rasa_pkg::result_word_t result_word
);

	localparam int AB = rasa_pkg::ANGLE_BITS;
	localparam int CW = rasa_pkg::COUNT_W;
	localparam int SW = rasa_pkg::SUM_W;
	localparam int RW = rasa_pkg::RANGE_W;
	localparam int DW = rasa_pkg::DIV_CNT_W;

	// Sequence state.
	logic [AB-1:0] first_q, prev_q, largest_q;
	logic [CW-1:0] count_q, ret_idx_q;
	logic          known_q, undet_q, ccw_q, ret_found_q;
	logic [SW-1:0] sum_q;

	// Division and pending summary.
	logic [SW-1:0] dq_q;
	logic [CW-1:0] rem_q, divisor_q, pend_proj_q;
	logic [AB-1:0] pend_rel_q, pend_largest_q;
	logic          pend_ccw_q;
	logic [DW-1:0] div_cnt_q;

	rasa_pkg::result_word_t out_q;

	logic [AB-1:0] a, first_n, rel, inc, largest_n;
	logic          fin, idx_first, decide, known_n, ccw_n, undet_n, stat_en;
	logic          ret_found_n;
	logic [CW-1:0] ret_idx_n, count_n, proj_n;
	logic [SW-1:0] sum_n;
	logic [1:0]    q1, q2;
	logic [CW:0]   trial, trial_diff;
	logic          trial_ge;

	always_comb begin
		a         = angle_word.angle_phase;
		fin       = angle_word.final_item;
		idx_first = (count_q == '0);
		decide    = (count_q == CW'(1)) && !known_q && !undet_q;
		q1        = first_q[AB-1 -: 2];
		q2        = a[AB-1 -: 2];
		known_n   = known_q;
		ccw_n     = ccw_q;
		undet_n   = undet_q;
		if (decide) begin
			if (q1 == rasa_pkg::QUAD_1 && q2 == rasa_pkg::QUAD_4) begin
				ccw_n   = 1'b1;
				known_n = 1'b1;
			end else if (q1 == rasa_pkg::QUAD_4 && q2 == rasa_pkg::QUAD_1) begin
				ccw_n   = 1'b0;
				known_n = 1'b1;
			end else if (a > first_q) begin
				ccw_n   = 1'b0;
				known_n = 1'b1;
			end else if (a < first_q) begin
				ccw_n   = 1'b1;
				known_n = 1'b1;
			end else begin
				undet_n = 1'b1;
			end
		end
		first_n = idx_first ? a : first_q;
		if (!known_n) begin
			rel = '0;
		end else if (ccw_n) begin
			rel = first_n - a;
		end else begin
			rel = a - first_n;
		end

		stat_en     = known_n && !idx_first && (count_q < CW'(rasa_pkg::MAX_ITEMS));
		inc         = rel - prev_q;
		sum_n       = sum_q;
		largest_n   = largest_q;
		ret_found_n = ret_found_q;
		ret_idx_n   = ret_idx_q;
		if (stat_en) begin
			sum_n = sum_q + SW'(inc);
			if (rel > largest_q) begin
				largest_n = rel;
			end
			if (rel == '0 && !ret_found_q) begin
				ret_found_n = 1'b1;
				ret_idx_n   = count_q;
			end
		end
		count_n = (count_q < CW'(rasa_pkg::MAX_ITEMS)) ? count_q + CW'(1) : count_q;
		proj_n  = ret_found_n ? ret_idx_n : count_n;

		status.need_div = fin && known_n && (count_n >= CW'(2));
		status.div_last = (div_cnt_q == '0);

		// One restoring division step: quotient bit shifts into dq_q.
		trial      = {rem_q, dq_q[SW-1]};
		trial_ge   = (trial >= {1'b0, divisor_q});
		trial_diff = trial - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= '0;
			prev_q      <= '0;
			largest_q   <= '0;
			count_q     <= '0;
			ret_idx_q   <= '0;
			known_q     <= 1'b0;
			undet_q     <= 1'b0;
			ccw_q       <= 1'b0;
			ret_found_q <= 1'b0;
			sum_q       <= '0;
			div_cnt_q   <= '0;
		end else if (cmd.accept) begin
			if (fin) begin
				first_q     <= '0;
				prev_q      <= '0;
				largest_q   <= '0;
				count_q     <= '0;
				ret_idx_q   <= '0;
				known_q     <= 1'b0;
				undet_q     <= 1'b0;
				ccw_q       <= 1'b0;
				ret_found_q <= 1'b0;
				sum_q       <= '0;
			end else begin
				first_q     <= first_n;
				if (stat_en) begin
					prev_q <= rel;
				end
				largest_q   <= largest_n;
				count_q     <= count_n;
				ret_idx_q   <= ret_idx_n;
				known_q     <= known_n;
				undet_q     <= undet_n;
				ccw_q       <= ccw_n;
				ret_found_q <= ret_found_n;
				sum_q       <= sum_n;
			end
			if (status.need_div) begin
				div_cnt_q <= DW'(rasa_pkg::DIV_STEPS - 1);
			end
		end else if (cmd.div_step && div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && status.need_div) begin
			dq_q           <= sum_n;
			rem_q          <= '0;
			divisor_q      <= count_n - CW'(1);
			pend_rel_q     <= rel;
			pend_ccw_q     <= ccw_n;
			pend_largest_q <= largest_n;
			pend_proj_q    <= proj_n;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[SW-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
		end

		if (cmd.load_item) begin
			out_q.relative_angle           <= rel;
			out_q.relative_valid           <= known_n;
			out_q.direction_ccw            <= known_n && ccw_n;
			out_q.summary_valid            <= 1'b0;
			out_q.mean_increment           <= '0;
			out_q.angle_range              <= '0;
			out_q.projections_per_rotation <= '0;
			out_q.result_last              <= fin;
		end else if (cmd.load_summary) begin
			out_q.relative_angle           <= pend_rel_q;
			out_q.relative_valid           <= 1'b1;
			out_q.direction_ccw            <= pend_ccw_q;
			out_q.summary_valid            <= 1'b1;
			out_q.mean_increment           <= dq_q[AB-1:0];
			out_q.angle_range              <= {1'b0, dq_q[AB-1:0]} + {1'b0, pend_largest_q};
			out_q.projections_per_rotation <= pend_proj_q;
			out_q.result_last              <= 1'b1;
		end
	end

	assign result_word = out_q;

endmodule

// File: design/rotation_angle_sequence_analyzer_top.sv
// Channel   Signals                                   Carries
// angle     angle_valid, angle_stall, angle_word      one phase word, final flag
// result    result_valid, result_stall, result_word   one result word per angle word
//
// Every angle word but a final one that starts the divider has its result loaded into the
// output register at the edge that takes it, so with a free receiver angle words stream
// at one per cycle. A final word that closes a sequence with a known direction starts a
// restoring divider that yields one quotient bit per cycle: angle_stall stays high for
// all its quotient bits and the summary load, and longer while a stalled result word
// holds the output register. Reset is asynchronous and clears the sequence state.
`include "rotation_angle_sequence_analyzer_top_macros.svh"

module rotation_angle_sequence_analyzer_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   angle_valid,
	output logic                   angle_stall,
	input  rasa_pkg::angle_word_t  angle_word,
	output logic                   result_valid,
	input  logic                   result_stall,
	output rasa_pkg::result_word_t result_word
);

	// Commands run from the controller to the datapath, status comes back.
	rasa_pkg::cmd_t    cmd;
	rasa_pkg::status_t status;

	// Terms used by the checks at the end.
	logic summary_out;
	logic summary_closed;
	logic proj_nonzero;

	// The controller owns the handshakes and the division sequencing.
	rasa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.angle_valid  (angle_valid),
		.angle_stall  (angle_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// The datapath holds the sequence statistics, the divider and the output word.
	rasa_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_word  (angle_word),
		.cmd         (cmd),
		.status      (status),
		.result_word (result_word)
	);

	assign summary_out    = result_valid && result_word.summary_valid;
	assign summary_closed = result_word.relative_valid && result_word.result_last;
	assign proj_nonzero   = (result_word.projections_per_rotation != '0);

	// A summary word always closes a sequence with a known direction.
	`RASA_ASSERT_NOW(a_summary_consistent, summary_out, summary_closed)

	// A sequence summary never reports zero projections.
	`RASA_ASSERT_NOW(a_projections_nonzero, summary_out, proj_nonzero)

	// Once a division starts, no further angle word is taken in the next cycle.
	`RASA_ASSERT_NEXT(a_div_blocks_input, cmd.accept && status.need_div, angle_stall)

endmodule

// File: tb/sv/tb_rotation_angle_sequence_analyzer_top.sv
`timescale 1ns / 100ps

module tb_rotation_angle_sequence_analyzer_top;

	localparam int AB = rasa_pkg::ANGLE_BITS;
	localparam int CW = rasa_pkg::COUNT_W;
	localparam int SW = rasa_pkg::SUM_W;

	// Clock, reset and the two channels of the block.
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   angle_valid = 1'b0;
	logic                   angle_stall;
	rasa_pkg::angle_word_t  angle_word = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b1;
	rasa_pkg::result_word_t result_word;

	// The expected result words, oldest first, one per accepted angle word.
	rasa_pkg::result_word_t expected_q[$];

	// When idle_on is clear, neither side inserts gaps, so that the block
	// also sees stretches of back-to-back words.
	bit idle_on = 1'b1;
	// A long receiver hold-off, in cycles, picked up by the receiver process.
	int hold_request = 0;

	int error_count = 0;
	int words_sent = 0;
	int sequences_sent = 0;
	int results_checked = 0;

	// Our own copy of the sequence state, rebuilt from what the block has taken.
	logic [AB-1:0] seq_first;
	logic [CW-1:0] seq_count;
	logic          dir_known;
	logic          dir_tied;
	logic          dir_ccw;
	logic [AB-1:0] last_rel;
	logic [SW-1:0] step_sum;
	logic [AB-1:0] peak_rel;
	logic [CW-1:0] zero_index;
	logic          zero_seen;

	rotation_angle_sequence_analyzer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.angle_valid  (angle_valid),
		.angle_stall  (angle_stall),
		.angle_word   (angle_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// A run that hangs is ended here; the limit is many times the slowest
	// correct run, divider passes and the longest stalls included.
	initial begin
		#10000000;
		$display("Timeout: %0d result words still outstanding", expected_q.size());
		$display("Some tests failed");
		$finish;
	end

	function automatic void clear_sequence();
		seq_first  = '0;
		seq_count  = '0;
		dir_known  = 1'b0;
		dir_tied   = 1'b0;
		dir_ccw    = 1'b0;
		last_rel   = '0;
		step_sum   = '0;
		peak_rel   = '0;
		zero_index = '0;
		zero_seen  = 1'b0;
	endfunction

	// Works out the result word for one accepted angle word and advances the
	// sequence state exactly as the block should.
	function automatic rasa_pkg::result_word_t predict_result(input rasa_pkg::angle_word_t w);
		rasa_pkg::result_word_t r;
		logic [AB-1:0]          a;
		logic [AB-1:0]          rel;
		logic [AB-1:0]          inc;
		logic [CW-1:0]          idx;
		logic [SW-1:0]          mean_full;
		logic [1:0]             quad_a;
		logic [1:0]             quad_first;
		r = '0;
		a = w.angle_phase;
		idx = seq_count;
		rel = '0;
		quad_a = a[AB-1 -: 2];
		quad_first = seq_first[AB-1 -: 2];

		// The first two angles settle the direction; a crossing between the
		// first and the fourth quadrant overrides the plain comparison.
		if (idx == 0) begin
			seq_first = a;
		end else if (idx == 1 && !dir_known && !dir_tied) begin
			if (quad_first == rasa_pkg::QUAD_1 && quad_a == rasa_pkg::QUAD_4) begin
				dir_ccw = 1'b1;
				dir_known = 1'b1;
			end else if (quad_first == rasa_pkg::QUAD_4 && quad_a == rasa_pkg::QUAD_1) begin
				dir_ccw = 1'b0;
				dir_known = 1'b1;
			end else if (a > seq_first) begin
				dir_ccw = 1'b0;
				dir_known = 1'b1;
			end else if (a < seq_first) begin
				dir_ccw = 1'b1;
				dir_known = 1'b1;
			end else begin
				dir_tied = 1'b1;
			end
		end

		if (dir_known) begin
			rel = dir_ccw ? seq_first - a : a - seq_first;
			// Words past the item limit still give an angle but are left out
			// of the statistics.
			if (idx >= 1 && idx < rasa_pkg::MAX_ITEMS) begin
				inc = rel - last_rel;
				step_sum = step_sum + inc;
				if (rel > peak_rel)
					peak_rel = rel;
				if (rel == 0 && !zero_seen) begin
					zero_seen = 1'b1;
					zero_index = idx;
				end
				last_rel = rel;
			end
		end

		if (seq_count < rasa_pkg::MAX_ITEMS)
			seq_count = seq_count + 1'b1;

		r.relative_angle = rel;
		r.relative_valid = dir_known;
		r.direction_ccw  = dir_known && dir_ccw;
		r.result_last    = w.final_item;
		if (w.final_item && dir_known && seq_count >= 2) begin
			mean_full = step_sum / (seq_count - 1'b1);
			r.summary_valid = 1'b1;
			r.mean_increment = mean_full[AB-1:0];
			r.angle_range = {1'b0, mean_full[AB-1:0]} + {1'b0, peak_rel};
			r.projections_per_rotation = zero_seen ? zero_index : seq_count;
		end

		if (w.final_item)
			clear_sequence();
		return r;
	endfunction

	// Offers one angle word after a random gap and returns at the falling
	// edge after it has been taken, leaving valid high so that a following
	// word with no gap goes out back to back.
	task automatic send_angle(input logic [AB-1:0] phase, input logic fin);
		int                     gap;
		rasa_pkg::angle_word_t  w;
		rasa_pkg::result_word_t want;
		gap = idle_on ? $urandom_range(0, 14) : 0;
		w.angle_phase = phase;
		w.final_item = fin;
		if (gap > 0) begin
			angle_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		angle_word = w;
		angle_valid = 1'b1;
		do @(posedge clk); while (angle_stall);
		want = predict_result(w);
		expected_q.insert(expected_q.size(), want);
		words_sent++;
		if (fin)
			sequences_sent++;
		@(negedge clk);
	endtask

	// Sends a steady rotation from start in the given direction; noise is the
	// chance, in percent, that a word is replaced by an arbitrary angle.
	task automatic send_sequence(input logic [AB-1:0] start,
			input logic [AB-1:0] step, input bit ccw, input int len,
			input int noise);
		logic [AB-1:0] a;
		int            offset;
		int            i;
		for (i = 0; i < len; i++) begin
			offset = step * i;
			a = ccw ? AB'(start - offset) : AB'(start + offset);
			if (noise > 0 && $urandom_range(0, 99) < noise)
				a = AB'($urandom);
			send_angle(a, i == len - 1);
		end
	endtask

	// Compares one accepted result word, field by field, with the oldest
	// expectation.
	task automatic check_result(input rasa_pkg::result_word_t got);
		rasa_pkg::result_word_t want;
		if (expected_q.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("%0t: result word with nothing expected: %h", $realtime, got);
			return;
		end
		want = expected_q.pop_front();
		results_checked++;
		if (got.relative_angle !== want.relative_angle
				|| got.relative_valid !== want.relative_valid
				|| got.direction_ccw !== want.direction_ccw
				|| got.summary_valid !== want.summary_valid
				|| got.mean_increment !== want.mean_increment
				|| got.angle_range !== want.angle_range
				|| got.projections_per_rotation !== want.projections_per_rotation
				|| got.result_last !== want.result_last) begin
			error_count++;
			if (error_count <= 10) begin
				$display("%0t: want rel %h/%b ccw %b sum %b mean %h rng %h proj %0d last %b",
					$realtime, want.relative_angle, want.relative_valid, want.direction_ccw,
					want.summary_valid, want.mean_increment, want.angle_range,
					want.projections_per_rotation, want.result_last);
				$display("%0t: got  rel %h/%b ccw %b sum %b mean %h rng %h proj %0d last %b",
					$realtime, got.relative_angle, got.relative_valid, got.direction_ccw,
					got.summary_valid, got.mean_increment, got.angle_range,
					got.projections_per_rotation, got.result_last);
			end
		end
	endtask

	// The receiver: before each result word it first holds off for a long stretch
	// when one has been asked for, then stalls for a random number of cycles, then takes
	// the word at the first edge where valid is high.
	initial begin
		int n;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				result_stall = 1'b1;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end
			n = idle_on ? $urandom_range(0, 14) : 0;
			if (n > 0) begin
				result_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			result_stall = 1'b0;
			do @(posedge clk); while (!result_valid);
			check_result(result_word);
		end
	end

	// Each rule for the direction, the extreme angles, a return to the first
	// angle, and sequences too short or too flat to give a direction.
	task automatic test_direction_rules();
		idle_on = 1'b1;
		// A single word can never give a direction or a summary.
		send_angle(16'h1234, 1'b1);
		send_angle(16'hFFFF, 1'b1);
		// Equal first and second angles leave the direction undetermined,
		// and a later different angle does not change that.
		send_angle(16'h0000, 1'b0);
		send_angle(16'h0000, 1'b1);
		send_angle(16'h8000, 1'b0);
		send_angle(16'h8000, 1'b0);
		send_angle(16'h9000, 1'b1);
		// Stepping from the first into the fourth quadrant is counter-clockwise.
		send_angle(16'h0000, 1'b0);
		send_angle(16'hFFFF, 1'b0);
		send_angle(16'hFFF0, 1'b1);
		// Stepping from the fourth into the first quadrant is clockwise.
		send_angle(16'hFFFF, 1'b0);
		send_angle(16'h0000, 1'b0);
		send_angle(16'h0010, 1'b1);
		// A larger second angle is clockwise; the fourth word returns exactly
		// to the first angle and sets the projection count.
		send_angle(16'h4000, 1'b0);
		send_angle(16'h5000, 1'b0);
		send_angle(16'h6000, 1'b0);
		send_angle(16'h4000, 1'b0);
		send_angle(16'h5000, 1'b1);
		// A smaller second angle is counter-clockwise.
		send_angle(16'h9000, 1'b0);
		send_angle(16'h8000, 1'b0);
		send_angle(16'h7000, 1'b0);
		send_angle(16'h9000, 1'b1);
		// The quadrant rule wins over the plain comparison in both directions.
		send_angle(16'h3FFF, 1'b0);
		send_angle(16'hC000, 1'b1);
		send_angle(16'hC000, 1'b0);
		send_angle(16'h3FFF, 1'b1);
	endtask

	// The receiver holds off for a long stretch while words keep coming, so
	// that the block fills up and stalls its input; the sender then waits
	// until every result word has come back.
	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_request = 300;
		send_sequence(AB'($urandom), AB'($urandom_range(1, 3000)),
			1'($urandom_range(0, 1)), 30, 0);
		send_sequence(AB'($urandom), 16'h0800, 1'($urandom_range(0, 1)), 35, 0);
		angle_valid = 1'b0;
		wait (expected_q.size() == 0);
		idle_on = 1'b1;
	endtask

	// Mostly well-formed rotations with random content, some of them coming
	// back exactly to the first angle, mixed with noise and broken sequences.
	task automatic test_random_sequences(input int target);
		int start_count;
		int pick;
		int len;
		int k;
		start_count = words_sent;
		while (words_sent - start_count < target) begin
			// Now and then a stretch with no idling on either side.
			if ($urandom_range(0, 9) == 0)
				idle_on = ~idle_on;
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_sequence(AB'($urandom), AB'($urandom_range(1, 3000)),
					1'($urandom_range(0, 1)), $urandom_range(2, 40), 0);
			end else if (pick < 65) begin
				// A step of a power of two that comes back round to zero.
				k = $urandom_range(11, 15);
				len = (65536 >> k) + $urandom_range(1, 5);
				send_sequence(AB'($urandom), AB'(1 << k), 1'($urandom_range(0, 1)),
					len, 0);
			end else if (pick < 75) begin
				send_sequence(AB'($urandom), AB'($urandom), 1'($urandom_range(0, 1)),
					$urandom_range(2, 20), 15);
			end else if (pick < 85) begin
				send_sequence(AB'($urandom), 16'h0000, 1'b0, $urandom_range(1, 20), 100);
			end else if (pick < 92) begin
				send_angle(AB'($urandom), 1'b1);
			end else begin
				// A flat start: the direction stays undetermined.
				send_sequence(AB'($urandom), 16'h0000, 1'b0, $urandom_range(2, 10), 0);
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		clear_sequence();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_direction_rules();
		test_backpressure();
		test_random_sequences(1760);

		angle_valid = 1'b0;
		wait (expected_q.size() == 0);
		// Keep running so that a stray extra result word would show up.
		repeat (64) @(posedge clk);

		$display("Sent %0d angle words in %0d sequences and checked %0d result words,",
			words_sent, sequences_sent, results_checked);
		$display("with random idling, back-to-back stretches, a long receiver hold-off and a drain.");
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/rasa_pkg.sv
design/rasa_ctrl.sv
design/rasa_datapath.sv
design/rotation_angle_sequence_analyzer_top.sv
tb/sv/tb_rotation_angle_sequence_analyzer_top.sv
